>>> hdl/assert_macros.svh
// Assertion helpers used by the clipper module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/lcw_pkg.sv
// ----------------------------------------------------------------------------
// Line clipper package
// Shared widths, kind codes and the token that travels down the divider chain.
// ----------------------------------------------------------------------------
package lcw_pkg;
    localparam int COORD_W = 12;
    localparam int WIN_W   = 11;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_VERT  = 2'd1,
        KIND_HORZ  = 2'd2,
        KIND_DIAG  = 2'd3
    } t_kind;

    typedef enum logic {
        REG_MAX_X = 1'b0,
        REG_MAX_Y = 1'b1
    } t_reg;

    typedef struct packed {
        logic                      valid;
        t_kind                     kind;
        logic                      vis;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W:0]   dx;
        logic signed [COORD_W:0]   dy;
        logic [WIN_W-1:0]          wx;
        logic [WIN_W-1:0]          wy;
        logic [WIN_W-1:0]          c0x;
        logic [WIN_W-1:0]          c0y;
        logic [WIN_W-1:0]          c1x;
        logic [WIN_W-1:0]          c1y;
    } t_tok;
endpackage

>>> hdl/lcw_div_cell.sv
// ----------------------------------------------------------------------------
// Restoring divider cell
// Produces one quotient bit per cell for four unsigned divisions in parallel.
// ----------------------------------------------------------------------------
module lcw_div_cell #(
    parameter int NW  = 32,
    parameter int DW  = 13,
    parameter int BIT = 0
) (
    input  logic                i_clk,
    input  logic [3:0][NW-1:0]  i_rem,
    input  logic [3:0][DW-1:0]  i_den,
    input  logic [3:0][NW-1:0]  i_quo,
    output logic [3:0][NW-1:0]  o_rem,
    output logic [3:0][DW-1:0]  o_den,
    output logic [3:0][NW-1:0]  o_quo
);
    logic [3:0][NW-1:0] n_rem, n_quo;
    logic [3:0][NW-1:0] r_rem, r_quo;
    logic [3:0][DW-1:0] r_den;

    always_comb begin
        logic [NW+DW-1:0] sh;
        for (int k = 0; k < 4; k++) begin
            sh = {{NW{1'b0}}, i_den[k]} << BIT;
            n_rem[k] = i_rem[k];
            n_quo[k] = i_quo[k];
            if ({{DW{1'b0}}, i_rem[k]} >= sh) begin
                n_rem[k] = i_rem[k] - sh[NW-1:0];
                n_quo[k][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= i_den;
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_den = r_den;
endmodule

>>> hdl/line_clip_to_window.sv
// ----------------------------------------------------------------------------
// Line clip to window
// Clips one segment per cycle to the configured window while the receiver does not stall.
// ----------------------------------------------------------------------------
// Usage: present start/end coordinates on the input channel with i_valid;
// a transfer happens when i_valid and o_ready are high. Results come out on
// the output channel (o_valid / i_ready) in input order, one per input.
// Each result passes through the chain of restoring divider cells
// (NB = FRAC_BITS + 13 quotient bits) that computes all four Liang-Barsky
// parameters, one quotient bit per cell, then the min/max, multiply and
// clamp stages. Throughput is one segment per cycle while the receiver does
// not stall. The whole pipeline advances only when the output register is
// empty or being taken, so a stalled receiver holds every stage and drops
// o_ready. Reset empties the pipeline and loads the window to 639 by 479.
// The user must write window registers through i_cfg_we, i_cfg_idx and
// i_cfg_data only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module line_clip_to_window #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [lcw_pkg::WIN_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [11:0]         i_start_x,
    input  logic signed [11:0]         i_start_y,
    input  logic signed [11:0]         i_end_x,
    input  logic signed [11:0]         i_end_y,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_visible,
    output logic [1:0]                 o_kind,
    output logic [10:0]                o_clip_x0,
    output logic [10:0]                o_clip_y0,
    output logic [10:0]                o_clip_x1,
    output logic [10:0]                o_clip_y1
);
    import lcw_pkg::*;
    `include "assert_macros.svh"

    localparam int NW = 13 + FRAC_BITS;     // numerator magnitude width
    localparam int NB = NW;                 // quotient bits, one per cell
    localparam int SW = NW + 1;             // signed quotient width
    localparam int PW = SW + 14;            // product width

    logic [WIN_W-1:0] r_wx, r_wy;
    logic             adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wx <= 11'd639;
            r_wy <= 11'd479;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MAX_X) r_wx <= i_cfg_data;
            else r_wy <= i_cfg_data;
        end
    end

    // ---------------- stage 0: classify, axis cases, numerators -------------
    t_tok             s0;
    logic [3:0][NW-1:0] s0_num;
    logic [3:0][12:0]   s0_den;
    logic [3:0]         s0_neg;

    always_comb begin
        logic signed [13:0] dx, dy, ax, ay, bx, by;
        logic signed [13:0] lo, hi, fx, fh, sh, a, b;
        logic vert;
        dx = 14'(i_end_x) - 14'(i_start_x);
        dy = 14'(i_end_y) - 14'(i_start_y);
        s0 = '0;
        s0.valid = i_valid;
        s0.x0 = i_start_x;
        s0.y0 = i_start_y;
        s0.dx = dx[12:0];
        s0.dy = dy[12:0];
        s0.wx = r_wx;
        s0.wy = r_wy;
        vert = (dx == 0);
        fx = vert ? 14'(i_start_x) : 14'(i_start_y);
        fh = vert ? 14'($signed({1'b0, r_wx})) : 14'($signed({1'b0, r_wy}));
        sh = vert ? 14'($signed({1'b0, r_wy})) : 14'($signed({1'b0, r_wx}));
        a = vert ? 14'(i_start_y) : 14'(i_start_x);
        b = vert ? 14'(i_end_y) : 14'(i_end_x);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (dx == 0 && dy == 0) begin
            s0.kind = KIND_POINT;
            s0.vis = (i_start_x >= 0) && (14'(i_start_x) <= 14'($signed({1'b0, r_wx})))
                  && (i_start_y >= 0) && (14'(i_start_y) <= 14'($signed({1'b0, r_wy})));
            s0.c0x = i_start_x[10:0];
            s0.c0y = i_start_y[10:0];
            s0.c1x = i_start_x[10:0];
            s0.c1y = i_start_y[10:0];
        end else if (dx == 0 || dy == 0) begin
            s0.kind = vert ? KIND_VERT : KIND_HORZ;
            s0.vis = !(fx < 0 || fx > fh || hi < 0 || lo > sh);
            if (lo < 0) lo = '0;
            if (hi > sh) hi = sh;
            if (vert) begin
                s0.c0x = fx[10:0]; s0.c0y = lo[10:0];
                s0.c1x = fx[10:0]; s0.c1y = hi[10:0];
            end else begin
                s0.c0x = lo[10:0]; s0.c0y = fx[10:0];
                s0.c1x = hi[10:0]; s0.c1y = fx[10:0];
            end
        end else begin
            s0.kind = KIND_DIAG;
            s0.vis = 1'b1;
        end
        // Numerators: ua = x0 / -dx, ub = (w - x0) / dx, same for y.
        ax = 14'(i_start_x);
        bx = 14'($signed({1'b0, r_wx})) - 14'(i_start_x);
        ay = 14'(i_start_y);
        by = 14'($signed({1'b0, r_wy})) - 14'(i_start_y);
        s0_num[0] = NW'(ax < 0 ? -ax : ax) << FRAC_BITS;
        s0_num[1] = NW'(bx < 0 ? -bx : bx) << FRAC_BITS;
        s0_num[2] = NW'(ay < 0 ? -ay : ay) << FRAC_BITS;
        s0_num[3] = NW'(by < 0 ? -by : by) << FRAC_BITS;
        s0_den[0] = dx < 0 ? 13'(-dx) : 13'(dx);
        s0_den[1] = s0_den[0];
        s0_den[2] = dy < 0 ? 13'(-dy) : 13'(dy);
        s0_den[3] = s0_den[2];
        // Sign of the quotient: numerator sign xor divisor sign.
        s0_neg[0] = (ax < 0) ^ (dx > 0);
        s0_neg[1] = (bx < 0) ^ (dx < 0);
        s0_neg[2] = (ay < 0) ^ (dy > 0);
        s0_neg[3] = (by < 0) ^ (dy < 0);
    end

    assign o_ready = adv;

    // ---------------- divider chain ----------------------------------------
    t_tok               tk  [0:NB];
    logic [3:0]         ng  [0:NB];
    logic [3:0][NW-1:0] rem [0:NB];
    logic [3:0][NW-1:0] quo [0:NB];
    logic [3:0][12:0]   den [0:NB];

    assign tk[0] = s0;
    assign ng[0] = s0_neg;
    assign rem[0] = s0_num;
    assign quo[0] = '0;
    assign den[0] = s0_den;

    for (genvar g = 0; g < NB; g++) begin : g_cell
        t_tok       r_tk;
        logic [3:0] r_ng;
        lcw_div_cell #(.NW(NW), .DW(13), .BIT(NB - 1 - g)) u_cell (
            .i_clk (i_clk),
            .i_rem (adv ? rem[g] : rem[g+1]),
            .i_den (adv ? den[g] : den[g+1]),
            .i_quo (adv ? quo[g] : quo[g+1]),
            .o_rem (rem[g+1]),
            .o_den (den[g+1]),
            .o_quo (quo[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_tk.valid <= 1'b0;
            else if (adv) r_tk.valid <= tk[g].valid;
            if (adv) begin
                r_tk[$bits(t_tok)-2:0] <= tk[g][$bits(t_tok)-2:0];
                r_ng <= ng[g];
            end
        end
        assign tk[g+1] = r_tk;
        assign ng[g+1] = r_ng;
    end

    // ---------------- stage A: u_min / u_max -------------------------------
    t_tok                r_ta;
    logic signed [SW-1:0] r_umin, r_umax;
    logic signed [SW-1:0] n_umin, n_umax;

    always_comb begin
        logic signed [SW-1:0] q [4];
        logic signed [SW-1:0] en, lv;
        for (int k = 0; k < 4; k++) begin
            q[k] = ng[NB][k] ? -$signed({1'b0, quo[NB][k]}) : $signed({1'b0, quo[NB][k]});
        end
        n_umin = '0;
        n_umax = SW'(1) <<< FRAC_BITS;
        en = tk[NB].dx[12] ? q[1] : q[0];
        lv = tk[NB].dx[12] ? q[0] : q[1];
        if (en > n_umin) n_umin = en;
        if (lv < n_umax) n_umax = lv;
        en = tk[NB].dy[12] ? q[3] : q[2];
        lv = tk[NB].dy[12] ? q[2] : q[3];
        if (en > n_umin) n_umin = en;
        if (lv < n_umax) n_umax = lv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ta.valid <= 1'b0;
        else if (adv) r_ta.valid <= tk[NB].valid;
        if (adv) begin
            r_ta[$bits(t_tok)-2:0] <= tk[NB][$bits(t_tok)-2:0];
            r_umin <= n_umin;
            r_umax <= n_umax;
        end
    end

    // ---------------- stage B: products ------------------------------------
    t_tok                r_tb;
    logic signed [PW-1:0] r_p [4];
    logic                 r_bvis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tb.valid <= 1'b0;
        else if (adv) r_tb.valid <= r_ta.valid;
        if (adv) begin
            r_tb[$bits(t_tok)-2:0] <= r_ta[$bits(t_tok)-2:0];
            r_bvis <= !(r_umin > r_umax);
            r_p[0] <= PW'(r_ta.dx) * PW'(r_umin);
            r_p[1] <= PW'(r_ta.dy) * PW'(r_umin);
            r_p[2] <= PW'(r_ta.dx) * PW'(r_umax);
            r_p[3] <= PW'(r_ta.dy) * PW'(r_umax);
        end
    end

    // ---------------- stage C: shift, add, clamp, output register ----------
    t_tok r_out;

    always_comb begin
        adv = !r_out.valid || i_ready;
    end

    always_ff @(posedge i_clk) begin
        logic signed [PW-1:0] v [4];
        logic signed [PW-1:0] hi;
        logic [WIN_W-1:0]     c [4];
        t_tok                 nx;
        for (int k = 0; k < 4; k++) begin
            hi = (k % 2 == 0) ? PW'($signed({1'b0, r_tb.wx}))
                              : PW'($signed({1'b0, r_tb.wy}));
            v[k] = ((k % 2 == 0) ? PW'(r_tb.x0) : PW'(r_tb.y0)) + (r_p[k] >>> FRAC_BITS);
            c[k] = (v[k] < 0) ? '0 : (v[k] > hi) ? hi[WIN_W-1:0] : v[k][WIN_W-1:0];
        end
        nx = r_tb;
        if (r_tb.kind == KIND_DIAG) begin
            nx.vis = r_bvis;
            nx.c0x = c[0]; nx.c0y = c[1];
            nx.c1x = c[2]; nx.c1y = c[3];
        end
        if (!i_rst_n) r_out.valid <= 1'b0;
        else if (adv) r_out.valid <= r_tb.valid;
        if (adv) begin
            r_out[$bits(t_tok)-2:0] <= nx[$bits(t_tok)-2:0];
        end
    end

    assign o_valid   = r_out.valid;
    assign o_visible = r_out.vis;
    assign o_kind    = r_out.kind;
    assign o_clip_x0 = r_out.vis ? r_out.c0x : '0;
    assign o_clip_y0 = r_out.vis ? r_out.c0y : '0;
    assign o_clip_x1 = r_out.vis ? r_out.c1x : '0;
    assign o_clip_y1 = r_out.vis ? r_out.c1y : '0;

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_kind))
    `ASSERT_IMP(a_ready, i_clk, i_rst_n, !o_valid, o_ready)
    `ASSERT_IMP(a_clamp, i_clk, i_rst_n, o_valid && o_visible,
        o_clip_x0 <= r_wx && o_clip_x1 <= r_wx && o_clip_y0 <= r_wy && o_clip_y1 <= r_wy)
endmodule
